### hw/rtl/mqttpp_pkg.sv
// Shared types and codes for the MQTT 5.0 packet parser.
// Used by the parser core, the result queue and the top level.
package mqttpp_pkg;

  // Kinds of result item.
  localparam logic [1:0] KIND_TOPIC   = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_SUBCODE = 2'd2;
  localparam logic [1:0] KIND_SUMMARY = 2'd3;

  // Summary status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_INCOMPLETE = 2'd1;
  localparam logic [1:0] ST_MALFORMED  = 2'd2;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd3;

  // Control packet types with special handling.
  localparam logic [3:0] T_CONNACK    = 4'd2;
  localparam logic [3:0] T_PUBLISH    = 4'd3;
  localparam logic [3:0] T_SUBACK     = 4'd9;
  localparam logic [3:0] T_UNSUBACK   = 4'd11;
  localparam logic [3:0] T_DISCONNECT = 4'd14;

  // One bit per supported packet type.
  localparam logic [15:0] SUPPORTED_MASK = 16'h6AFC;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       buffer_last;
  } in_t;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [7:0]  data_byte;
    logic [3:0]  packet_type;
    logic [3:0]  header_flags;
    logic [15:0] packet_ident;
    logic [7:0]  ack_code;
    logic        session_present;
    logic [6:0]  topic_len;
    logic [10:0] payload_len;
    logic [4:0]  reason_count;
    logic [1:0]  status;
    logic        run_last;
  } out_t;

  // Up to two result items produced by one input item, data item first.
  typedef struct packed {
    logic       v0;
    logic       v1;
    out_t       r0;
    out_t       r1;
  } res_pair_t;

endpackage

### hw/rtl/mqttpp_parser.sv
// Parser core: holds the parse state and turns one accepted byte into up to two items.
// Depends on mqttpp_pkg.
module mqttpp_parser import mqttpp_pkg::*; #(
  parameter int TOPIC_MAX   = 128,
  parameter int PAYLOAD_MAX = 1024,
  parameter int MAX_SUBS    = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  in_t       in_i,
  output res_pair_t res_o
);

  localparam int TW = (TOPIC_MAX > 2) ? $clog2(TOPIC_MAX) : 1;
  localparam int PW = $clog2(PAYLOAD_MAX + 1);
  localparam int SW = $clog2(MAX_SUBS + 1);

  localparam logic [3:0] PH_FIRST    = 4'd0;
  localparam logic [3:0] PH_RLEN     = 4'd1;
  localparam logic [3:0] PH_TLEN_HI  = 4'd2;
  localparam logic [3:0] PH_TLEN_LO  = 4'd3;
  localparam logic [3:0] PH_TOPIC    = 4'd4;
  localparam logic [3:0] PH_PID_HI   = 4'd5;
  localparam logic [3:0] PH_PID_LO   = 4'd6;
  localparam logic [3:0] PH_ACKFLAGS = 4'd7;
  localparam logic [3:0] PH_REASON   = 4'd8;
  localparam logic [3:0] PH_PLEN     = 4'd9;
  localparam logic [3:0] PH_PROPS    = 4'd10;
  localparam logic [3:0] PH_PAYLOAD  = 4'd11;
  localparam logic [3:0] PH_SUBCODES = 4'd12;
  localparam logic [3:0] PH_SKIP     = 4'd13;
  localparam logic [3:0] PH_DONE     = 4'd14;

  logic [3:0]  ph_q, ph_d;
  logic [7:0]  tf_q, tf_d;
  logic [27:0] acc_q, acc_d;
  logic [1:0]  lbc_q, lbc_d;
  logic [28:0] pos_q, pos_d;
  logic [27:0] fc_q, fc_d;
  logic [15:0] pid_q, pid_d;
  logic [7:0]  rc_q, rc_d;
  logic        sp_q, sp_d;
  logic [TW-1:0] tc_q, tc_d;
  logic [PW-1:0] pc_q, pc_d;
  logic [SW-1:0] sc_q, sc_d;

  logic       have_data, have_sum;
  logic [1:0] data_kind, sum_status;
  out_t       data_item, sum_item;

  function automatic logic [27:0] place7(input logic [6:0] b7, input logic [1:0] idx);
    logic [27:0] r;
    r = '0;
    unique case (idx)
      2'd0: r = {21'd0, b7};
      2'd1: r = {14'd0, b7, 7'd0};
      2'd2: r = {7'd0, b7, 14'd0};
      2'd3: r = {b7, 21'd0};
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] first_phase(input logic [3:0] t);
    logic [3:0] p;
    p = PH_SKIP;
    if (t == T_CONNACK) p = PH_ACKFLAGS;
    else if (t == T_PUBLISH) p = PH_TLEN_HI;
    else if (t == T_SUBACK || (t >= 4'd4 && t <= 4'd7) || t == T_UNSUBACK) p = PH_PID_HI;
    else if (t == T_DISCONNECT) p = PH_REASON;
    return p;
  endfunction

  function automatic logic [3:0] next_phase(input logic [3:0] p, input logic [7:0] tf);
    logic [3:0] r;
    r = PH_SKIP;
    unique case (p)
      PH_TLEN_HI:  r = PH_TLEN_LO;
      PH_TLEN_LO:  r = PH_TOPIC;
      PH_TOPIC:    r = (tf[2:1] != 2'd0) ? PH_PID_HI : PH_PLEN;
      PH_PID_HI:   r = PH_PID_LO;
      PH_PID_LO:   r = (tf[7:4] == T_SUBACK || tf[7:4] == T_PUBLISH) ? PH_PLEN : PH_REASON;
      PH_ACKFLAGS: r = PH_REASON;
      PH_REASON:   r = (tf[7:4] == T_DISCONNECT) ? PH_SKIP : PH_PLEN;
      PH_PLEN:     r = PH_PROPS;
      PH_PROPS: begin
        if (tf[7:4] == T_PUBLISH) r = PH_PAYLOAD;
        else if (tf[7:4] == T_SUBACK) r = PH_SUBCODES;
        else r = PH_SKIP;
      end
      default:     r = PH_SKIP;
    endcase
    return r;
  endfunction

  // Skips a topic or property field that is empty.
  function automatic logic [3:0] enter_phase(input logic [3:0] p, input logic zero,
                                             input logic [7:0] tf);
    logic [3:0] r;
    r = p;
    if (r == PH_TOPIC && zero) r = next_phase(r, tf);
    if (r == PH_PROPS && zero) r = next_phase(r, tf);
    return r;
  endfunction

  always_comb begin
    logic [7:0] b;
    logic [3:0] np;
    b = in_i.stream_byte;
    np = PH_FIRST;
    ph_d = ph_q; tf_d = tf_q; acc_d = acc_q; lbc_d = lbc_q; pos_d = pos_q;
    fc_d = fc_q; pid_d = pid_q; rc_d = rc_q; sp_d = sp_q;
    tc_d = tc_q; pc_d = pc_q; sc_d = sc_q;
    have_data = 1'b0; data_kind = KIND_TOPIC;
    have_sum = 1'b0; sum_status = ST_OK;

    unique case (ph_q)
      PH_FIRST: begin
        tf_d = b; acc_d = '0; lbc_d = '0; ph_d = PH_RLEN;
      end
      PH_RLEN: begin
        acc_d = acc_q | place7(b[6:0], lbc_q);
        if (b[7]) begin
          if (lbc_q == 2'd3) begin
            have_sum = 1'b1; sum_status = ST_MALFORMED;
          end else begin
            lbc_d = lbc_q + 2'd1;
          end
        end else begin
          pos_d = '0;
          if (acc_d == '0) begin
            have_sum = 1'b1;
            sum_status = SUPPORTED_MASK[tf_q[7:4]] ? ST_OK : ST_UNSUPPORTED;
          end else begin
            np = enter_phase(first_phase(tf_q[7:4]), fc_q == '0, tf_q);
            ph_d = np;
            if (np == PH_PLEN) begin
              fc_d = '0; lbc_d = '0;
            end
          end
        end
      end
      PH_DONE: begin
      end
      default: begin
        pos_d = pos_q + 29'd1;
        unique case (ph_q)
          PH_TLEN_HI: begin
            fc_d = {12'd0, b, 8'd0}; ph_d = PH_TLEN_LO;
          end
          PH_TLEN_LO: begin
            fc_d = fc_q | {20'd0, b};
            np = enter_phase(PH_TOPIC, fc_d == '0, tf_q);
            ph_d = np;
            if (np == PH_PLEN) begin
              fc_d = '0; lbc_d = '0;
            end
          end
          PH_TOPIC: begin
            if (32'(tc_q) < 32'(TOPIC_MAX - 1)) begin
              have_data = 1'b1; data_kind = KIND_TOPIC;
              tc_d = tc_q + TW'(1);
            end
            fc_d = fc_q - 28'd1;
            if (fc_d == '0) begin
              np = next_phase(PH_TOPIC, tf_q);
              ph_d = np;
              if (np == PH_PLEN) begin
                fc_d = '0; lbc_d = '0;
              end
            end
          end
          PH_PID_HI: begin
            pid_d = {b, 8'd0}; ph_d = PH_PID_LO;
          end
          PH_PID_LO: begin
            pid_d = {pid_q[15:8], b};
            np = next_phase(PH_PID_LO, tf_q);
            ph_d = np;
            if (np == PH_PLEN) begin
              fc_d = '0; lbc_d = '0;
            end
          end
          PH_ACKFLAGS: begin
            sp_d = b[0]; ph_d = PH_REASON;
          end
          PH_REASON: begin
            rc_d = b;
            np = next_phase(PH_REASON, tf_q);
            ph_d = np;
            if (np == PH_PLEN) begin
              fc_d = '0; lbc_d = '0;
            end
          end
          PH_PLEN: begin
            fc_d = fc_q | place7(b[6:0], lbc_q);
            if (b[7]) begin
              if (lbc_q == 2'd3) begin
                have_sum = 1'b1; sum_status = ST_MALFORMED;
                ph_d = PH_DONE;
              end else begin
                lbc_d = lbc_q + 2'd1;
              end
            end else begin
              ph_d = enter_phase(PH_PROPS, fc_d == '0, tf_q);
            end
          end
          PH_PROPS: begin
            fc_d = fc_q - 28'd1;
            if (fc_d == '0) ph_d = next_phase(PH_PROPS, tf_q);
          end
          PH_PAYLOAD: begin
            if (32'(pc_q) < 32'(PAYLOAD_MAX)) begin
              have_data = 1'b1; data_kind = KIND_PAYLOAD;
              pc_d = pc_q + PW'(1);
            end
          end
          PH_SUBCODES: begin
            if (32'(sc_q) < 32'(MAX_SUBS)) begin
              have_data = 1'b1; data_kind = KIND_SUBCODE;
              sc_d = sc_q + SW'(1);
            end
          end
          default: begin
          end
        endcase
        if (!have_sum && pos_d >= {1'b0, acc_q}) begin
          have_sum = 1'b1;
          sum_status = SUPPORTED_MASK[tf_q[7:4]] ? ST_OK : ST_UNSUPPORTED;
        end
      end
    endcase

    if (have_sum) ph_d = PH_DONE;

    // A buffer that ends before the packet does closes it as incomplete.
    if (in_i.buffer_last && !have_sum && ph_d != PH_DONE) begin
      have_sum = 1'b1; sum_status = ST_INCOMPLETE;
    end

    data_item = '0;
    data_item.item_kind    = data_kind;
    data_item.data_byte    = b;
    data_item.packet_type  = tf_d[7:4];
    data_item.header_flags = tf_d[3:0];

    sum_item = '0;
    sum_item.item_kind       = KIND_SUMMARY;
    sum_item.packet_type     = tf_d[7:4];
    sum_item.header_flags    = tf_d[3:0];
    sum_item.packet_ident    = pid_d;
    sum_item.ack_code        = rc_d;
    sum_item.session_present = sp_d;
    sum_item.topic_len       = 7'(tc_d);
    sum_item.payload_len     = 11'(pc_d);
    sum_item.reason_count    = 5'(sc_d);
    sum_item.status          = sum_status;
    sum_item.run_last        = 1'b1;

    if (in_i.buffer_last) begin
      ph_d = PH_FIRST; tf_d = '0; acc_d = '0; lbc_d = '0; pos_d = '0; fc_d = '0;
      pid_d = '0; rc_d = '0; sp_d = 1'b0; tc_d = '0; pc_d = '0; sc_d = '0;
    end

    res_o.v0 = have_data | have_sum;
    res_o.v1 = have_data & have_sum;
    res_o.r0 = have_data ? data_item : sum_item;
    res_o.r1 = sum_item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_FIRST; tf_q <= '0; acc_q <= '0; lbc_q <= '0; pos_q <= '0; fc_q <= '0;
      pid_q <= '0; rc_q <= '0; sp_q <= 1'b0; tc_q <= '0; pc_q <= '0; sc_q <= '0;
    end else if (accept_i) begin
      ph_q <= ph_d; tf_q <= tf_d; acc_q <= acc_d; lbc_q <= lbc_d; pos_q <= pos_d;
      fc_q <= fc_d; pid_q <= pid_d; rc_q <= rc_d; sp_q <= sp_d;
      tc_q <= tc_d; pc_q <= pc_d; sc_q <= sc_d;
    end
  end

endmodule

### hw/rtl/mqttpp_outq.sv
// Four-entry result queue that takes up to two items per cycle and hands out one when not stalled.
// Depends on mqttpp_pkg.
module mqttpp_outq import mqttpp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  res_pair_t res_i,
  output logic      full_o,
  output logic      valid_o,
  input  logic      stall_i,
  output out_t      data_o
);

  out_t       mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic       pop;
  logic [1:0] n_push;

  assign pop     = valid_o & ~stall_i;
  assign n_push  = push_i ? ({1'b0, res_i.v0} + {1'b0, res_i.v1}) : 2'd0;
  assign valid_o = cnt_q != 3'd0;
  assign data_o  = mem_q[rd_q];
  // Room for two more items must exist before the next byte is taken.
  assign full_o  = cnt_q > 3'd2;

  always_ff @(posedge clk_i) begin
    if (push_i && res_i.v0) mem_q[wr_q] <= res_i.r0;
    if (push_i && res_i.v1) mem_q[wr_q + 2'd1] <= res_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + n_push;
      rd_q  <= rd_q + {1'b0, pop};
      cnt_q <= cnt_q + {1'b0, n_push} - {2'b0, pop};
    end
  end

endmodule

### hw/rtl/mqtt5_client_packet_parser_top.sv
// MQTT 5.0 packet parser, top level. Takes one buffer byte per cycle while the queue has room.
// A byte's items are written into a four-entry result queue when the byte is accepted
// and leave it through the output port. A byte gives at most two items and the output
// side drains one item per cycle when it is not stalled.
// Reset (asynchronous, active low) returns the parser to waiting for a first byte
// and empties the queue.
module mqtt5_client_packet_parser_top import mqttpp_pkg::*; #(
  parameter int TOPIC_MAX   = 128,
  parameter int PAYLOAD_MAX = 1024,
  parameter int MAX_SUBS    = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic      accept;
  logic      q_full;
  res_pair_t res;

  // The input stalls only on queue occupancy, never on the input valid.
  assign in_stall_o = q_full;
  assign accept     = in_valid_i & ~q_full;

  // The parser state advances on each accepted byte; its items go straight
  // into the queue in the same cycle.
  mqttpp_parser #(
    .TOPIC_MAX  (TOPIC_MAX),
    .PAYLOAD_MAX(PAYLOAD_MAX),
    .MAX_SUBS   (MAX_SUBS)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .in_i    (in_data_i),
    .res_o   (res)
  );

  // The queue separates the two sides so a waiting item does not block input.
  mqttpp_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .res_i  (res),
    .full_o (q_full),
    .valid_o(out_valid_o),
    .stall_i(out_stall_i),
    .data_o (out_data_o)
  );

endmodule

### bench/testbench.sv
// Self-checking bench for the MQTT 5.0 packet parser top level.
// Depends on mqttpp_pkg and mqtt5_client_packet_parser_top from the RTL.
`timescale 1ns / 100ps

module testbench;
  import mqttpp_pkg::*;

  // Parse phases of the bench's own copy of the parser state.
  typedef enum int {
    P_FIRST, P_RLEN, P_TLEN_HI, P_TLEN_LO, P_TOPIC, P_PID_HI, P_PID_LO, P_ACKFLAGS,
    P_REASON, P_PLEN, P_PROPS, P_PAYLOAD, P_SUBCODES, P_SKIP, P_DONE
  } phase_e;

  localparam int TOPIC_LIMIT   = 128;
  localparam int PAYLOAD_LIMIT = 1024;
  localparam int SUBS_LIMIT    = 16;
  localparam int ITEM_TARGET   = 1550;
  localparam int CALM_FROM     = 1350;
  localparam int STUCK_LIMIT   = 5000;

  // One row of the directed table: a byte, its end-of-buffer mark and,
  // where the outcome is plain, the summary item it must give.
  typedef struct {
    logic [7:0] b;
    logic       is_last;
    bit         typed;
    out_t       want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  mqtt5_client_packet_parser_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mirror of the parser state.
  phase_e      phase;
  logic [7:0]  type_flags;
  logic [27:0] remaining;
  logic [2:0]  len_bytes;
  logic [28:0] body_pos;
  logic [27:0] countdown;
  logic [15:0] pkt_id;
  logic [7:0]  ack_reason;
  logic        session_flag;
  logic [6:0]  topic_seen;
  logic [10:0] payload_seen;
  logic [4:0]  subcode_seen;

  // Items caused by the byte being predicted, and the items still owed.
  out_t new_items[2];
  int   new_count;
  out_t owed_items[$];

  int   mismatches = 0;
  bit   failed = 1'b0;
  bit   gaps_on = 1'b1;
  int   items_sent = 0;
  int   stall_left = 0;
  int   stuck_cycles = 0;

  logic [7:0] body[$];
  logic [7:0] buffer_bytes[$];
  row_t       directed[$];

  function automatic void clear_parse();
    phase = P_FIRST;
    type_flags = '0;
    remaining = '0;
    len_bytes = '0;
    body_pos = '0;
    countdown = '0;
    pkt_id = '0;
    ack_reason = '0;
    session_flag = 1'b0;
    topic_seen = '0;
    payload_seen = '0;
    subcode_seen = '0;
  endfunction

  function automatic void add_data(logic [1:0] kind, logic [7:0] b);
    out_t r;
    r = '0;
    r.item_kind = kind;
    r.data_byte = b;
    r.packet_type = type_flags[7:4];
    r.header_flags = type_flags[3:0];
    new_items[new_count] = r;
    new_count++;
  endfunction

  function automatic void add_summary(logic [1:0] st);
    out_t r;
    r.item_kind = KIND_SUMMARY;
    r.data_byte = '0;
    r.packet_type = type_flags[7:4];
    r.header_flags = type_flags[3:0];
    r.packet_ident = pkt_id;
    r.ack_code = ack_reason;
    r.session_present = session_flag;
    r.topic_len = topic_seen;
    r.payload_len = payload_seen;
    r.reason_count = subcode_seen;
    r.status = st;
    r.run_last = 1'b1;
    new_items[new_count] = r;
    new_count++;
    phase = P_DONE;
  endfunction

  function automatic logic [1:0] end_status();
    return SUPPORTED_MASK[type_flags[7:4]] ? ST_OK : ST_UNSUPPORTED;
  endfunction

  function automatic phase_e opening_phase(logic [3:0] t);
    if (t == T_CONNACK) return P_ACKFLAGS;
    if (t == T_PUBLISH) return P_TLEN_HI;
    if (t == T_SUBACK || (t >= 4'd4 && t <= 4'd7) || t == T_UNSUBACK) return P_PID_HI;
    if (t == T_DISCONNECT) return P_REASON;
    return P_SKIP;
  endfunction

  function automatic phase_e following_phase(phase_e p);
    logic [3:0] t;
    t = type_flags[7:4];
    case (p)
      P_TLEN_HI: return P_TLEN_LO;
      P_TLEN_LO: return P_TOPIC;
      P_TOPIC: return (type_flags[2:1] != 2'd0) ? P_PID_HI : P_PLEN;
      P_PID_HI: return P_PID_LO;
      P_PID_LO: return (t == T_SUBACK || t == T_PUBLISH) ? P_PLEN : P_REASON;
      P_ACKFLAGS: return P_REASON;
      P_REASON: return (t == T_DISCONNECT) ? P_SKIP : P_PLEN;
      P_PLEN: return P_PROPS;
      P_PROPS: begin
        if (t == T_PUBLISH) return P_PAYLOAD;
        if (t == T_SUBACK) return P_SUBCODES;
        return P_SKIP;
      end
      default: return P_SKIP;
    endcase
  endfunction

  // Empty topic or property fields are passed over at once.
  function automatic void go_to(phase_e p);
    while ((p == P_TOPIC || p == P_PROPS) && countdown == '0) p = following_phase(p);
    if (p == P_PLEN) begin
      countdown = '0;
      len_bytes = '0;
    end
    phase = p;
  endfunction

  // Works out the items that one accepted byte gives.
  function automatic void parse_byte(logic [7:0] b, logic is_last);
    new_count = 0;
    case (phase)
      P_FIRST: begin
        type_flags = b;
        remaining = '0;
        len_bytes = '0;
        phase = P_RLEN;
      end
      P_RLEN: begin
        remaining = remaining | (28'(b[6:0]) << (7 * len_bytes[1:0]));
        if (b[7]) begin
          if (len_bytes >= 3'd3) add_summary(ST_MALFORMED);
          else len_bytes++;
        end else begin
          body_pos = '0;
          if (remaining == '0) add_summary(end_status());
          else go_to(opening_phase(type_flags[7:4]));
        end
      end
      P_DONE: ;
      default: begin
        body_pos++;
        case (phase)
          P_TLEN_HI: begin
            countdown = 28'(b) << 8;
            phase = P_TLEN_LO;
          end
          P_TLEN_LO: begin
            countdown = countdown | 28'(b);
            go_to(P_TOPIC);
          end
          P_TOPIC: begin
            if (topic_seen < 7'(TOPIC_LIMIT - 1)) begin
              add_data(KIND_TOPIC, b);
              topic_seen++;
            end
            countdown--;
            if (countdown == '0) go_to(following_phase(P_TOPIC));
          end
          P_PID_HI: begin
            pkt_id = {b, 8'h00};
            phase = P_PID_LO;
          end
          P_PID_LO: begin
            pkt_id[7:0] = b;
            go_to(following_phase(P_PID_LO));
          end
          P_ACKFLAGS: begin
            session_flag = b[0];
            phase = P_REASON;
          end
          P_REASON: begin
            ack_reason = b;
            go_to(following_phase(P_REASON));
          end
          P_PLEN: begin
            countdown = countdown | (28'(b[6:0]) << (7 * len_bytes[1:0]));
            if (b[7]) begin
              if (len_bytes >= 3'd3) add_summary(ST_MALFORMED);
              else len_bytes++;
            end else begin
              go_to(P_PROPS);
            end
          end
          P_PROPS: begin
            countdown--;
            if (countdown == '0) go_to(following_phase(P_PROPS));
          end
          P_PAYLOAD: begin
            if (payload_seen < 11'(PAYLOAD_LIMIT)) begin
              add_data(KIND_PAYLOAD, b);
              payload_seen++;
            end
          end
          P_SUBCODES: begin
            if (subcode_seen < 5'(SUBS_LIMIT)) begin
              add_data(KIND_SUBCODE, b);
              subcode_seen++;
            end
          end
          default: ;
        endcase
        if (phase != P_DONE && 29'(remaining) <= body_pos) add_summary(end_status());
      end
    endcase
    if (is_last) begin
      if (phase != P_DONE) add_summary(ST_INCOMPLETE);
      clear_parse();
    end
  endfunction

  // Offers one byte, waits for it to be taken, then records what it owes.
  // A typed row replaces the predicted summary with the one written in the table.
  task automatic send_byte(logic [7:0] b, logic is_last, bit typed, out_t want);
    bit took;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{stream_byte: b, buffer_last: is_last};
    do begin
      @(negedge clk_i);
      took = !in_stall_o;
      @(posedge clk_i);
    end while (!took);
    parse_byte(b, is_last);
    if (typed) begin
      owed_items.push_back(want);
    end else begin
      for (int i = 0; i < new_count; i++) owed_items.push_back(new_items[i]);
    end
    items_sent++;
  endtask

  function automatic out_t summary_of(logic [3:0] t, logic [3:0] f, logic [7:0] rc,
                                      logic sp, logic [1:0] st);
    out_t r;
    r = '0;
    r.item_kind = KIND_SUMMARY;
    r.packet_type = t;
    r.header_flags = f;
    r.ack_code = rc;
    r.session_present = sp;
    r.status = st;
    r.run_last = 1'b1;
    return r;
  endfunction

  function automatic void row(logic [7:0] b, logic is_last);
    directed.push_back('{b: b, is_last: is_last, typed: 1'b0, want: '0});
  endfunction

  function automatic void typed_row(logic [7:0] b, out_t want);
    directed.push_back('{b: b, is_last: 1'b1, typed: 1'b1, want: want});
  endfunction

  // Remaining-length style variable byte integer.
  function automatic void push_varint(int unsigned v);
    logic [7:0] b;
    do begin
      b = 8'(v & 127);
      v = v >> 7;
      if (v != 0) b[7] = 1'b1;
      body.push_back(b);
    end while (v != 0);
  endfunction

  function automatic void push_random(int n);
    for (int i = 0; i < n; i++) body.push_back(8'($urandom_range(0, 255)));
  endfunction

  // A property block, now and then with a property length that never ends.
  function automatic void push_props();
    int n;
    if ($urandom_range(0, 24) == 0) begin
      repeat (4) body.push_back(8'($urandom_range(128, 255)));
    end else begin
      n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
      push_varint(n);
      push_random(n);
    end
  endfunction

  // Builds one receive buffer. Most are well-formed packets of the types the
  // parser decodes; the rest have short lengths, early ends, trailing junk,
  // malformed remaining lengths or unsupported types.
  function automatic void build_buffer();
    logic [3:0] t;
    logic [3:0] f;
    int n;
    int mode;
    int unsigned rem;
    logic [3:0] decoded[10] = '{4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd9, 4'd11, 4'd13,
                                4'd14};
    body.delete();
    buffer_bytes.delete();
    t = ($urandom_range(0, 9) < 8) ? decoded[$urandom_range(0, 9)] : 4'($urandom_range(0, 15));
    f = 4'($urandom_range(0, 15));
    case (t)
      T_PUBLISH: begin
        n = ($urandom_range(0, 149) == 0) ? $urandom_range(128, 140) : $urandom_range(0, 5);
        body.push_back(8'(n >> 8));
        body.push_back(8'(n));
        push_random(n);
        if (f[2:1] != 2'd0) push_random(2);
        push_props();
        n = ($urandom_range(0, 179) == 0) ? $urandom_range(1025, 1030) : $urandom_range(0, 8);
        push_random(n);
      end
      T_CONNACK: begin
        push_random(2);
        push_props();
      end
      T_SUBACK: begin
        push_random(2);
        push_props();
        push_random(($urandom_range(0, 9) == 0) ? $urandom_range(15, 20) : $urandom_range(0, 4));
      end
      4'd4, 4'd5, 4'd6, 4'd7, T_UNSUBACK: begin
        push_random(3);
        push_props();
        push_random($urandom_range(0, 2));
      end
      T_DISCONNECT: push_random($urandom_range(0, 4));
      default: push_random($urandom_range(0, 6));
    endcase
    rem = body.size();
    mode = $urandom_range(0, 9);
    if (mode == 0 && rem > 0) begin
      rem = $urandom_range(0, rem - 1);
      while (body.size() > rem) void'(body.pop_back());
    end
    buffer_bytes.push_back({t, f});
    if (mode == 3) begin
      repeat ($urandom_range(4, 5)) buffer_bytes.push_back(8'($urandom_range(128, 255)));
    end else begin
      n = body.size();
      body.delete();
      push_varint(rem);
      foreach (body[i]) buffer_bytes.push_back(body[i]);
      body.delete();
      push_random(n);
    end
    if (mode == 1 && body.size() > 0) void'(body.pop_back());
    if (mode == 2) push_random($urandom_range(1, 4));
    foreach (body[i]) buffer_bytes.push_back(body[i]);
    if (mode == 1 && buffer_bytes.size() > 1 && $urandom_range(0, 1) == 0)
      void'(buffer_bytes.pop_back());
  endfunction

  // Output side: random stall bursts, none in the closing part of the run.
  always @(posedge clk_i) begin
    if (stall_left > 0) stall_left--;
    else if (gaps_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 16);
    out_stall_i <= (stall_left > 0);
  end

  // Results are compared at the falling edge before the rising edge that takes them.
  always @(negedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (owed_items.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected item at %0t: kind %0d type %0d", $realtime,
                   out_data_o.item_kind, out_data_o.packet_type);
      end else begin
        want = owed_items.pop_front();
        if (out_data_o !== want) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10) begin
            $write("Mismatch at %0t: kind %0d/%0d byte %h/%h type %h/%h flags %h/%h ",
                   $realtime, want.item_kind, out_data_o.item_kind,
                   want.data_byte, out_data_o.data_byte,
                   want.packet_type, out_data_o.packet_type,
                   want.header_flags, out_data_o.header_flags);
            $write("id %h/%h rc %h/%h sp %b/%b tl %0d/%0d pl %0d/%0d rcnt %0d/%0d ",
                   want.packet_ident, out_data_o.packet_ident,
                   want.ack_code, out_data_o.ack_code,
                   want.session_present, out_data_o.session_present,
                   want.topic_len, out_data_o.topic_len,
                   want.payload_len, out_data_o.payload_len,
                   want.reason_count, out_data_o.reason_count);
            $display("st %0d/%0d end %b/%b (expected/actual)",
                     want.status, out_data_o.status, want.run_last, out_data_o.run_last);
          end
        end
      end
    end
  end

  // Watchdog: ends the run when neither side has moved an item for too long.
  always @(negedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    int buffers;
    clear_parse();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. PINGRESP with zero remaining length.
    row(8'hD0, 1'b0);
    typed_row(8'h00, summary_of(4'd13, 4'h0, 8'h00, 1'b0, ST_OK));
    // A remaining length whose fourth byte still has its continuation bit set.
    row(8'h3F, 1'b0);
    row(8'hFF, 1'b0);
    row(8'hFF, 1'b0);
    row(8'hFF, 1'b0);
    typed_row(8'hFF, summary_of(T_PUBLISH, 4'hF, 8'h00, 1'b0, ST_MALFORMED));
    // Unsupported type with an empty body.
    row(8'hF0, 1'b0);
    typed_row(8'h00, summary_of(4'd15, 4'h0, 8'h00, 1'b0, ST_UNSUPPORTED));
    // CONNACK with session present and a failure reason code.
    row(8'h20, 1'b0);
    row(8'h03, 1'b0);
    row(8'h01, 1'b0);
    row(8'h87, 1'b0);
    typed_row(8'h00, summary_of(T_CONNACK, 4'h0, 8'h87, 1'b1, ST_OK));
    // PUBLISH whose buffer ends after the first byte of the body.
    row(8'h30, 1'b0);
    row(8'h05, 1'b0);
    typed_row(8'h00, summary_of(T_PUBLISH, 4'h0, 8'h00, 1'b0, ST_INCOMPLETE));
    // PUBLISH at QoS 1 with a one-byte topic and two payload bytes.
    row(8'h32, 1'b0);
    row(8'h08, 1'b0);
    row(8'h00, 1'b0);
    row(8'h01, 1'b0);
    row(8'h61, 1'b0);
    row(8'h12, 1'b0);
    row(8'h34, 1'b0);
    row(8'h00, 1'b0);
    row(8'h55, 1'b0);
    row(8'h66, 1'b1);
    // SUBACK with two reason codes, then DISCONNECT with a reason.
    row(8'h90, 1'b0);
    row(8'h05, 1'b0);
    row(8'h00, 1'b0);
    row(8'h0A, 1'b0);
    row(8'h00, 1'b0);
    row(8'h00, 1'b0);
    row(8'h80, 1'b1);
    row(8'hE0, 1'b0);
    row(8'h01, 1'b0);
    row(8'h8E, 1'b1);

    foreach (directed[i])
      send_byte(directed[i].b, directed[i].is_last, directed[i].typed, directed[i].want);

    // Random part: one buffer at a time.
    buffers = 0;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= CALM_FROM) gaps_on = 1'b0;
      if (buffers == 60) begin
        // Hold the input back until every owed item has come out.
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (owed_items.size() != 0);
      end
      build_buffer();
      foreach (buffer_bytes[i])
        send_byte(buffer_bytes[i], i == buffer_bytes.size() - 1, 1'b0, '0);
      buffers++;
    end
    in_valid_i <= 1'b0;

    while (owed_items.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (!failed && owed_items.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
